FILE: design/sdsc_pkg.sv
// shared types, codes and helpers for the sd spi command sequencer
`timescale 1ns / 1ps

package sdsc_pkg;

  // action codes of an input transaction
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_RX    = 1'b1;

  // result kinds
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  // frame and polling constants
  localparam logic [7:0]  CMD_START_BITS   = 8'h40;
  localparam logic [7:0]  POLL_BYTE        = 8'hFF;
  localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;
  localparam logic [2:0]  FRAME_BYTES      = 3'd6;

  // depth of the result queue
  localparam int unsigned RES_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        action;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  crc_byte;
    logic [3:0]  response_length;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_value;
    logic       select_active;
    logic [7:0] response_byte;
    logic [2:0] response_position;
    logic       last;
    logic       timed_out;
  } result_t;

  // transmit request for one byte
  function automatic result_t make_tx(input logic [7:0] value);
    result_t r;
    r                   = '0;
    r.kind              = KIND_TX;
    r.tx_value          = value;
    r.select_active     = 1'b1;
    return r;
  endfunction

  // received response byte
  function automatic result_t make_resp(input logic [7:0] value, input logic [2:0] pos,
                                        input logic fin, input logic timed);
    result_t r;
    r                   = '0;
    r.kind              = KIND_RESP;
    r.select_active     = ~fin;
    r.response_byte     = value;
    r.response_position = pos;
    r.last              = fin;
    r.timed_out         = timed;
    return r;
  endfunction

endpackage

FILE: design/sdsc_stream_if.sv
// valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps

interface sdsc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/sd_spi_command_transaction_core.sv
// Byte-level sequencer for one SD-card SPI-mode command exchange. A start
// transaction raises chip select and issues the six frame bytes, then 0xFF polls
// until a response byte with its top bit clear arrives (or poll_limit runs out,
// flagging timed_out), then reads the remaining response bytes. One input
// transaction can be taken every clock cycle; its results (none, one or two)
// are computed in the same cycle and written into a four-entry result queue,
// which hands out one result per cycle while the result side is ready. Input
// ready is low while fewer than two queue entries are free, so with the result
// side always ready the block sustains one transaction per cycle while each
// yields a single result. A response byte that is not the last yields two
// results (the byte and the next 0xFF poll), so a run of those is limited by
// the output to half the input rate.
`timescale 1ns / 1ps

module sd_spi_command_transaction_core #(
  parameter int unsigned MAX_RESPONSE_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  sdsc_stream_if.sink   item_i,
  sdsc_stream_if.source result_o
);

  logic                    accept;
  logic                    room;
  sdsc_pkg::result_t [1:0] res;
  logic [1:0]              res_cnt;

  // input transaction accepted when there is room for two results
  assign item_i.ready = room;
  assign accept       = item_i.valid && room;

  // sequencer state and next-state logic
  sdsc_sequencer #(
    .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
  ) u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (item_i.payload),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  // result queue decoupling the output side
  sdsc_result_queue u_result_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push_data_i (res),
    .room_o      (room),
    .res_o       (result_o)
  );

endmodule

FILE: design/sdsc_sequencer.sv
// command/response sequencer state and per-transaction next-state logic
`timescale 1ns / 1ps

module sdsc_sequencer #(
  parameter int unsigned MAX_RESPONSE_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        accept_i,
  input  sdsc_pkg::item_t             item_i,
  output sdsc_pkg::result_t [1:0]     res_o,
  output logic [1:0]                  res_cnt_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_POLL  = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  logic [15:0] poll_limit_q;
  logic [1:0]  phase_q, phase_d;
  logic [39:0] frame_shift_q, frame_shift_d;
  logic [2:0]  frame_pos_q, frame_pos_d;
  logic [15:0] polls_left_q, polls_left_d;
  logic [3:0]  expected_q, expected_d;
  logic [3:0]  received_q, received_d;
  logic        expired_q, expired_d;

  // poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= sdsc_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

  // next state and results of one transaction
  always_comb begin
    logic       take;
    logic [3:0] len;
    logic [3:0] rc;
    logic       fin;
    logic [15:0] pl;
    take          = 1'b0;
    len           = item_i.response_length;
    rc            = received_q + 4'd1;
    fin           = (rc >= expected_q);
    pl            = polls_left_q;
    phase_d       = phase_q;
    frame_shift_d = frame_shift_q;
    frame_pos_d   = frame_pos_q;
    polls_left_d  = polls_left_q;
    expected_d    = expected_q;
    received_d    = received_q;
    expired_d     = expired_q;
    res_o         = '0;
    res_cnt_o     = 2'd0;
    if (accept_i) begin
      if (item_i.action == sdsc_pkg::ACT_START) begin
        if (phase_q == PH_IDLE) begin
          if (len == 4'd0) begin
            len = 4'd1;
          end
          if (32'(len) > MAX_RESPONSE_BYTES) begin
            len = 4'(MAX_RESPONSE_BYTES);
          end
          expected_d    = len;
          received_d    = 4'd0;
          expired_d     = 1'b0;
          polls_left_d  = (poll_limit_q == 16'd0) ? 16'd1 : poll_limit_q;
          res_o[0]      = sdsc_pkg::make_tx(sdsc_pkg::CMD_START_BITS
                                            | {2'b00, item_i.command_index});
          res_cnt_o     = 2'd1;
          frame_shift_d = {item_i.argument, item_i.crc_byte};
          frame_pos_d   = 3'd1;
          phase_d       = PH_FRAME;
        end
      end else begin
        case (phase_q)
          PH_FRAME: begin
            res_cnt_o = 2'd1;
            if (frame_pos_q < sdsc_pkg::FRAME_BYTES) begin
              res_o[0]      = sdsc_pkg::make_tx(frame_shift_q[39:32]);
              frame_shift_d = {frame_shift_q[31:0], 8'h00};
              frame_pos_d   = frame_pos_q + 3'd1;
            end else begin
              res_o[0] = sdsc_pkg::make_tx(sdsc_pkg::POLL_BYTE);
              phase_d  = PH_POLL;
            end
          end
          PH_POLL: begin
            if (!item_i.rx_byte[7]) begin
              take = 1'b1;
            end else begin
              if (polls_left_q != 16'd0) begin
                pl = polls_left_q - 16'd1;
              end
              polls_left_d = pl;
              if (pl == 16'd0) begin
                expired_d = 1'b1;
                take      = 1'b1;
              end else begin
                res_o[0]  = sdsc_pkg::make_tx(sdsc_pkg::POLL_BYTE);
                res_cnt_o = 2'd1;
              end
            end
          end
          PH_READ: begin
            take = 1'b1;
          end
          default: begin
            take = 1'b0;
          end
        endcase
        // response byte, then another poll unless it was the final one
        if (take) begin
          received_d = rc;
          res_o[0]   = sdsc_pkg::make_resp(item_i.rx_byte, received_q[2:0], fin, expired_d);
          if (fin) begin
            phase_d   = PH_IDLE;
            res_cnt_o = 2'd1;
          end else begin
            phase_d   = PH_READ;
            res_o[1]  = sdsc_pkg::make_tx(sdsc_pkg::POLL_BYTE);
            res_cnt_o = 2'd2;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      frame_shift_q <= '0;
      frame_pos_q   <= '0;
      polls_left_q  <= '0;
      expected_q    <= '0;
      received_q    <= '0;
      expired_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      frame_shift_q <= frame_shift_d;
      frame_pos_q   <= frame_pos_d;
      polls_left_q  <= polls_left_d;
      expected_q    <= expected_d;
      received_q    <= received_d;
      expired_q     <= expired_d;
    end
  end

  // polling always leaves before the budget reaches zero
  a_poll_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_POLL) |-> (polls_left_q != 16'd0))
    else $error("poll phase with no polls left");

  // a busy transaction always expects at least one response byte
  a_expected_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (expected_q != 4'd0))
    else $error("busy with zero expected bytes");

  // frame position never runs past the six frame bytes
  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_pos_q <= sdsc_pkg::FRAME_BYTES))
    else $error("frame position out of range");

  // a start accepted while idle always enters the frame phase
  a_start_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.action == sdsc_pkg::ACT_START && phase_q == PH_IDLE)
    |=> (phase_q == PH_FRAME && frame_pos_q == 3'd1))
    else $error("start did not enter frame phase");

endmodule

FILE: design/sdsc_result_queue.sv
// small result queue taking up to two results a cycle and giving one
`timescale 1ns / 1ps

module sdsc_result_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              push_cnt_i,
  input  sdsc_pkg::result_t [1:0] push_data_i,
  output logic                    room_o,
  sdsc_stream_if.source           res_o
);

  localparam int unsigned DEPTH = sdsc_pkg::RES_QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sdsc_pkg::result_t entries_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_nx;

  assign pop       = res_o.valid && res_o.ready;
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign room_o    = (count_q <= CNT_W'(DEPTH - 2));

  assign res_o.valid   = (count_q != '0);
  assign res_o.payload = entries_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entries_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      entries_q[wr_ptr_nx] <= push_data_i[1];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt_i);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_cnt_i) - CNT_W'(pop);
    end
  end

  // never fill beyond the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (count_q <= CNT_W'(DEPTH - 2)))
    else $error("result queue overflow");

  // fill count stays within the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(DEPTH)))
    else $error("result queue count out of range");

  // pointers agree with the count
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(count_q)))
    else $error("result queue pointers and count disagree");

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the sd spi command sequencer core
`timescale 1ns / 1ps

module testbench;
  import sdsc_pkg::*;

  localparam int unsigned MAX_RESP = 8;

  typedef enum logic [1:0] {PH_IDLE, PH_FRAME, PH_POLL, PH_READ} seq_phase_e;

  // one line of the directed table: either a register write or an item
  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg_val;
    item_t       it;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sdsc_stream_if #(.T(item_t))   item_if ();
  sdsc_stream_if #(.T(result_t)) res_if ();

  sd_spi_command_transaction_core #(
    .MAX_RESPONSE_BYTES(MAX_RESP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  // shadow state of the sequencer
  seq_phase_e  seq_phase;
  logic [47:0] frame_left;
  logic [2:0]  frame_sent;
  logic [15:0] polls_left;
  logic [3:0]  resp_expected;
  logic [3:0]  resp_taken;
  logic        poll_ran_out;
  logic [15:0] poll_limit_cfg;

  result_t  step_out[$];
  result_t  awaited_results[$];
  dir_row_t dir_rows[$];
  int       answered_items;
  int       mismatches;
  bit       tx_quiet;
  bit       rx_quiet;
  bit       hold_req;
  int       hold_left;

  function automatic result_t tx_req(input logic [7:0] v);
    result_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx_value = v;
    r.select_active = 1'b1;
    return r;
  endfunction

  function automatic result_t resp_of(input logic [7:0] b, input logic [2:0] pos,
                                      input logic fin, input logic timed);
    result_t r;
    r = '0;
    r.kind = KIND_RESP;
    r.select_active = ~fin;
    r.response_byte = b;
    r.response_position = pos;
    r.last = fin;
    r.timed_out = timed;
    return r;
  endfunction

  function automatic item_t start_item(input logic [5:0] cmd, input logic [31:0] arg,
                                       input logic [7:0] crc, input logic [3:0] len);
    item_t it;
    it = '0;
    it.action = ACT_START;
    it.command_index = cmd;
    it.argument = arg;
    it.crc_byte = crc;
    it.response_length = len;
    return it;
  endfunction

  function automatic item_t rx_item(input logic [7:0] b);
    item_t it;
    it = '0;
    it.action = ACT_RX;
    it.rx_byte = b;
    return it;
  endfunction

  // emit one response byte and move on to the next read or back to idle
  function automatic void take_response(input logic [7:0] b);
    logic [2:0] pos;
    logic       fin;
    pos = resp_taken[2:0];
    resp_taken = resp_taken + 4'd1;
    fin = (resp_taken >= resp_expected);
    step_out.push_back(resp_of(b, pos, fin, poll_ran_out));
    if (fin) begin
      seq_phase = PH_IDLE;
    end else begin
      seq_phase = PH_READ;
      step_out.push_back(tx_req(POLL_BYTE));
    end
  endfunction

  // results caused by one accepted transaction, left in step_out
  function automatic void predict_exchange(input item_t it);
    logic [3:0]  len;
    logic [47:0] frame;
    step_out = {};
    if (it.action == ACT_START) begin
      if (seq_phase != PH_IDLE) return;
      len = it.response_length;
      if (len == 4'd0) len = 4'd1;
      if (len > MAX_RESP) len = MAX_RESP[3:0];
      resp_expected = len;
      resp_taken = 4'd0;
      poll_ran_out = 1'b0;
      polls_left = (poll_limit_cfg == 16'd0) ? 16'd1 : poll_limit_cfg;
      frame = {CMD_START_BITS | {2'b00, it.command_index}, it.argument, it.crc_byte};
      step_out.push_back(tx_req(frame[47:40]));
      frame_left = frame << 8;
      frame_sent = 3'd1;
      seq_phase = PH_FRAME;
      return;
    end
    case (seq_phase)
      PH_FRAME: begin
        if (frame_sent < FRAME_BYTES) begin
          step_out.push_back(tx_req(frame_left[47:40]));
          frame_left = frame_left << 8;
          frame_sent = frame_sent + 3'd1;
        end else begin
          step_out.push_back(tx_req(POLL_BYTE));
          seq_phase = PH_POLL;
        end
      end
      PH_POLL: begin
        if (!it.rx_byte[7]) begin
          take_response(it.rx_byte);
        end else begin
          if (polls_left > 16'd0) polls_left = polls_left - 16'd1;
          if (polls_left == 16'd0) begin
            poll_ran_out = 1'b1;
            take_response(it.rx_byte);
          end else begin
            step_out.push_back(tx_req(POLL_BYTE));
          end
        end
      end
      PH_READ: take_response(it.rx_byte);
      default: ;
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // well-formed exchanges with random content, plus some noise
  function automatic item_t pick_item();
    item_t it;
    int    r;
    it.action = ACT_RX;
    it.command_index = 6'($urandom_range(0, 63));
    it.argument = $urandom;
    it.crc_byte = 8'($urandom_range(0, 255));
    it.response_length = 4'($urandom_range(1, MAX_RESP));
    it.rx_byte = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.action = 1'($urandom_range(0, 1));
      it.response_length = 4'($urandom_range(0, 15));
      return it;
    end
    case (seq_phase)
      PH_IDLE: begin
        it.action = ACT_START;
        if ($urandom_range(0, 7) == 0) it.response_length = 4'($urandom_range(0, 15));
      end
      PH_POLL: it.rx_byte[7] = ($urandom_range(0, 99) < 65);
      default: ;
    endcase
    return it;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // offer one transaction, record what it should cause, then maybe idle
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int gap;
    item_if.valid <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    predict_exchange(it);
    if (typed && step_out.size() > 0) step_out[0] = want;
    foreach (step_out[k]) awaited_results.push_back(step_out[k]);
    if (step_out.size() > 0) answered_items++;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write once the block has gone quiet
  task automatic write_limit(input logic [15:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    poll_limit_cfg = v;
    cfg_we_i <= 1'b0;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls and one long hold-off
  initial begin
    res_if.ready <= 1'b0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 120;
        res_if.ready <= 1'b0;
      end else begin
        hold_left = pick_gap(rx_quiet);
        if (hold_left > 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got_r;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got_r = res_if.payload;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0h", $time, got_r);
        mismatches++;
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("kind", 8'(exp_r.kind), 8'(got_r.kind));
        check_field("tx_value", exp_r.tx_value, got_r.tx_value);
        check_field("select_active", 8'(exp_r.select_active), 8'(got_r.select_active));
        check_field("response_byte", exp_r.response_byte, got_r.response_byte);
        check_field("response_position", 8'(exp_r.response_position),
                    8'(got_r.response_position));
        check_field("last", 8'(exp_r.last), 8'(got_r.last));
        check_field("timed_out", 8'(exp_r.timed_out), 8'(got_r.timed_out));
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] limits[6];
    int          target;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'd0;
    item_if.valid <= 1'b0;
    item_if.payload <= '0;
    seq_phase = PH_IDLE;
    frame_left = '0;
    frame_sent = '0;
    polls_left = '0;
    resp_expected = '0;
    resp_taken = '0;
    poll_ran_out = 1'b0;
    poll_limit_cfg = POLL_LIMIT_RESET;
    answered_items = 0;
    mismatches = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset limit, ignored items, extremes, short lengths
    dir_rows.push_back('{0, 16'd0, rx_item(8'hFF), 0, '0});
    dir_rows.push_back('{0, 16'd0, start_item(6'd0, 32'h0, 8'h00, 4'd0), 1, tx_req(8'h40)});
    dir_rows.push_back('{0, 16'd0, start_item(6'd63, 32'hFFFF_FFFF, 8'hFF, 4'd15), 0, '0});
    dir_rows.push_back('{0, 16'd0, rx_item(8'hFF), 1, tx_req(8'h00)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h80), 1, tx_req(8'h00)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h00), 1, tx_req(8'h00)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h7F), 1, tx_req(8'h00)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h55), 1, tx_req(8'h00)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'hAA), 1, tx_req(POLL_BYTE)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'hFF), 1, tx_req(POLL_BYTE)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h00), 1, resp_of(8'h00, 3'd0, 1'b1, 1'b0)});
    // zero poll limit acts as one: the first busy poll runs out
    dir_rows.push_back('{1, 16'd0, '0, 0, '0});
    dir_rows.push_back('{0, 16'd0, start_item(6'd63, 32'hFFFF_FFFF, 8'hFF, 4'd2), 1,
                         tx_req(8'h7F)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h00), 1, tx_req(8'hFF)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h01), 1, tx_req(8'hFF)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h02), 1, tx_req(8'hFF)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h04), 1, tx_req(8'hFF)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h08), 1, tx_req(8'hFF)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h10), 1, tx_req(POLL_BYTE)});
    dir_rows.push_back('{0, 16'd0, rx_item(8'hFF), 0, '0});
    dir_rows.push_back('{0, 16'd0, rx_item(8'h00), 1, resp_of(8'h00, 3'd1, 1'b1, 1'b1)});
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_limit(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under its own poll limit
    limits[0] = 16'd1;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd2;
    limits[3] = 16'd0;
    limits[4] = 16'($urandom_range(1, 6));
    limits[5] = POLL_LIMIT_RESET;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      tx_quiet = (ph == 1);
      rx_quiet = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      target = answered_items + 250;
      while (answered_items < target) send_item(pick_item(), 1'b0, '0);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
